// ===== rtl/jse_pkg.sv =====
// Shared types, character constants and helpers for the JSON string escaper.
`default_nettype none
package jse_pkg;

	localparam int MAX_CHARS = 8;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	localparam logic [7:0] BYTE_BS   = 8'h08;
	localparam logic [7:0] BYTE_HT   = 8'h09;
	localparam logic [7:0] BYTE_LF   = 8'h0A;
	localparam logic [7:0] BYTE_FF   = 8'h0C;
	localparam logic [7:0] BYTE_CR   = 8'h0D;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] BYTE_DEL  = 8'h7F;
	localparam logic [7:0] HIGH_BASE = 8'h80;

	// Bit positions in the option register.
	localparam int OPT_QUOTES   = 0;
	localparam int OPT_HEX_HIGH = 1;
	localparam int OPT_UNI_DEL  = 2;
	localparam int OPT_HEX_NPRT = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_start;
		logic       string_end;
		logic       empty_string;
	} item_t;

	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [3:0]                count;
	} seq_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] d;
		if (nib < 4'd10) begin
			d = CH_ZERO + {4'd0, nib};
		end else begin
			d = 8'h57 + {4'd0, nib};
		end
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/jse_in_if.sv =====
// Input channel interface: one raw byte of a string with its markers.
`default_nettype none
interface jse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_start;
	logic       string_end;
	logic       empty_string;

	modport source(output valid, in_byte, string_start, string_end, empty_string,
		input ready);
	modport sink(input valid, in_byte, string_start, string_end, empty_string,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/jse_out_if.sv =====
// Output channel interface: one character of escaped text.
`default_nettype none
interface jse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_of_run;

	modport source(output valid, out_char, last_of_run, input ready);
	modport sink(input valid, out_char, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/jse_cfg_if.sv =====
// Configuration write channel interface for the option register.
`default_nettype none
interface jse_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/json_string_escaper.sv =====
// Top level of the JSON string escaper: input register, expansion logic and drain.
// A word waits in the input register; its expansion then loads the drain register.
// Throughput: one word per cycle while each word yields a single character and the
// output is ready; a longer expansion (up to 8 characters) holds the drain register.
// Reset clears the option register and all valid flags; no output is pending after it.
`default_nettype none
module json_string_escaper (
	input  logic      clk,
	input  logic      arst_n,
	jse_in_if.sink    in_ch,
	jse_out_if.source out_ch,
	jse_cfg_if.sink   cfg
);
	import jse_pkg::*;

	logic [3:0] opt_q;
	item_t      item_s1;
	logic       valid_s1;
	item_t      in_item;
	seq_t       seq;
	logic       load_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opt_q <= 4'd0;
		end else if (cfg.valid) begin
			opt_q <= cfg.data;
		end
	end

	assign in_item.in_byte      = in_ch.in_byte;
	assign in_item.string_start = in_ch.string_start;
	assign in_item.string_end   = in_ch.string_end;
	assign in_item.empty_string = in_ch.empty_string;

	assign in_ch.ready = !valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_item;
		end
	end

	jse_expand u_expand (
		.item (item_s1),
		.opt  (opt_q),
		.seq  (seq)
	);

	jse_drain u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.seq        (seq),
		.load_valid (valid_s1),
		.load_ready (load_ready),
		.out        (out_ch)
	);

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_ready) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled word");

endmodule
`default_nettype wire

// ===== rtl/jse_expand.sv =====
// Combinational expansion of one input word into its escaped character sequence.
`default_nettype none
module jse_expand (
	input  jse_pkg::item_t item,
	input  logic [3:0]     opt,
	output jse_pkg::seq_t  seq
);
	import jse_pkg::*;

	localparam logic [1:0] K_PLAIN  = 2'd0;
	localparam logic [1:0] K_ESC    = 2'd1;
	localparam logic [1:0] K_WIDE   = 2'd2;
	localparam logic [1:0] K_NARROW = 2'd3;

	logic [1:0] kind;
	logic [7:0] esc_char;
	logic [7:0] b;
	logic [7:0] hi_digit;
	logic [7:0] lo_digit;
	logic       quotes;
	logic [MAX_CHARS-1:0][7:0] chars;
	logic [3:0] k;

	assign b        = item.in_byte;
	assign quotes   = opt[OPT_QUOTES];
	assign hi_digit = hex_digit(b[7:4]);
	assign lo_digit = hex_digit(b[3:0]);

	always_comb begin
		kind     = K_PLAIN;
		esc_char = b;
		case (b)
			CH_QUOTE:  begin kind = K_ESC; esc_char = CH_QUOTE;  end
			CH_BSLASH: begin kind = K_ESC; esc_char = CH_BSLASH; end
			BYTE_BS:   begin kind = K_ESC; esc_char = CH_B; end
			BYTE_FF:   begin kind = K_ESC; esc_char = CH_F; end
			BYTE_LF:   begin kind = K_ESC; esc_char = CH_N; end
			BYTE_CR:   begin kind = K_ESC; esc_char = CH_R; end
			BYTE_HT:   begin kind = K_ESC; esc_char = CH_T; end
			default: begin
				if (b < CTRL_LIMIT) begin
					kind = K_WIDE;
				end else if (b >= HIGH_BASE && opt[OPT_HEX_HIGH]) begin
					kind = K_NARROW;
				end else if (b == BYTE_DEL && opt[OPT_UNI_DEL]) begin
					kind = K_WIDE;
				end else if (b >= BYTE_DEL && opt[OPT_HEX_NPRT]) begin
					kind = K_NARROW;
				end else begin
					kind = K_PLAIN;
				end
			end
		endcase
	end

	// At most eight characters: opening quote, six for a wide escape, closing quote.
	always_comb begin
		chars = '0;
		k     = 4'd0;
		if (item.empty_string) begin
			if (quotes) begin
				chars[0] = CH_QUOTE;
				chars[1] = CH_QUOTE;
				k = 4'd2;
			end
		end else begin
			if (quotes && item.string_start) begin
				chars[k[2:0]] = CH_QUOTE;
				k = k + 4'd1;
			end
			case (kind)
				K_PLAIN: begin
					chars[k[2:0]] = b;
					k = k + 4'd1;
				end
				K_ESC: begin
					chars[k[2:0]] = CH_BSLASH;
					k = k + 4'd1;
					chars[k[2:0]] = esc_char;
					k = k + 4'd1;
				end
				K_WIDE: begin
					chars[k[2:0]] = CH_BSLASH;
					k = k + 4'd1;
					chars[k[2:0]] = CH_U;
					k = k + 4'd1;
					chars[k[2:0]] = CH_ZERO;
					k = k + 4'd1;
					chars[k[2:0]] = CH_ZERO;
					k = k + 4'd1;
					chars[k[2:0]] = hi_digit;
					k = k + 4'd1;
					chars[k[2:0]] = lo_digit;
					k = k + 4'd1;
				end
				K_NARROW: begin
					chars[k[2:0]] = CH_BSLASH;
					k = k + 4'd1;
					chars[k[2:0]] = CH_X;
					k = k + 4'd1;
					chars[k[2:0]] = hi_digit;
					k = k + 4'd1;
					chars[k[2:0]] = lo_digit;
					k = k + 4'd1;
				end
				default: begin
					chars[k[2:0]] = b;
					k = k + 4'd1;
				end
			endcase
			if (quotes && item.string_end) begin
				chars[k[2:0]] = CH_QUOTE;
				k = k + 4'd1;
			end
		end
	end

	assign seq.chars = chars;
	assign seq.count = k;

endmodule
`default_nettype wire

// ===== rtl/jse_drain.sv =====
// Result register: holds one sequence, gives a character per cycle while out.ready is high.
`default_nettype none
module jse_drain (
	input  logic          clk,
	input  logic          arst_n,
	input  jse_pkg::seq_t seq,
	input  logic          load_valid,
	output logic          load_ready,
	jse_out_if.source     out
);
	import jse_pkg::*;

	seq_t       seq_q;
	logic [2:0] idx_q;
	logic       valid_q;
	logic       last;
	logic       take;
	logic       done;

	assign last       = ({1'b0, idx_q} == (seq_q.count - 4'd1));
	assign take       = valid_q && out.ready;
	assign done       = !valid_q || (take && last);
	assign load_ready = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (done) begin
			// A word that expands to nothing is dropped here.
			valid_q <= load_valid && (seq.count != 4'd0);
			idx_q   <= 3'd0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (done && load_valid) begin
			seq_q <= seq;
		end
	end

	assign out.valid       = valid_q;
	assign out.out_char    = seq_q.chars[idx_q];
	assign out.last_of_run = last;

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (seq_q.count != 4'd0))
		else $error("drain holds an empty sequence");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ({1'b0, idx_q} < seq_q.count))
		else $error("drain index past sequence end");

	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out.ready && !last) |=> (valid_q && idx_q == $past(idx_q) + 3'd1))
		else $error("drain index did not advance by one");

endmodule
`default_nettype wire
